[rtl/afq_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and widths for the audio frame queue.
package afq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam int LEN_W   = 16;
    localparam int STAMP_W = 64;
    localparam int TOTAL_W = 21;
    localparam int SUM_W   = 22;
    localparam int RATE_W  = 18;
    localparam int FMT_W   = 8;
    localparam int CHAN_W  = 4;
    localparam int SBITS_W = 6;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 3;
    localparam int DROP_W  = 5;
    localparam int ECNT_W  = 5;
    localparam int CTR_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam logic [MODE_W-1:0] MODE_SUBMIT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_UNSUPPORTED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NO_SESSION  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY       = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUEUE_BYTES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_BYTES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_FORMAT        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_RATE          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_CHANNELS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_SAMPLE_BITS   = 3'd5;

    localparam logic [TOTAL_W-1:0] RST_MAX_QUEUE_BYTES = 21'd65536;
    localparam logic [LEN_W-1:0]   RST_MAX_FRAME_BYTES = 16'd16384;
    localparam logic [FMT_W-1:0]   RST_REQ_FORMAT      = 8'd1;
    localparam logic [RATE_W-1:0]  RST_REQ_RATE        = 18'd48000;
    localparam logic [CHAN_W-1:0]  RST_REQ_CHANNELS    = 4'd2;
    localparam logic [SBITS_W-1:0] RST_REQ_SAMPLE_BITS = 6'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_TAKE,
        S_WRITE,
        S_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ring_ctl;

endpackage

[rtl/audio_frame_queue_drop_oldest.sv]
`timescale 1ns / 1ps
// Audio frame descriptor queue with a byte budget that drops the oldest frames.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+-----------------------------------
//  request  | in        | i_in_valid / o_in_stall     | i_mode, frame fields, session bits
//  result   | out       | o_out_valid / i_out_stall   | o_status ... o_submitted_total
//  config   | in        | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// A request transfers only while the controller is idle. A fitting submit passes evaluate,
// write and check before the result loads; each budget drop adds a take and a check, and a
// drop on a full ring a take. A pop evaluates and takes; flush, clear and a rejected submit
// only evaluate. The read port returns data the cycle after its address; one descriptor per step.
// Reset is synchronous and active low; it empties the queue, zeroes the counters and restores
// the register defaults. A stalled result holds back only the final load of the next result.
module audio_frame_queue_drop_oldest #(
    parameter int QUEUE_DEPTH = afq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [afq_pkg::MODE_W-1:0]        i_mode,
    input  logic [afq_pkg::LEN_W-1:0]         i_frame_bytes,
    input  logic                              i_data_present,
    input  logic [afq_pkg::FMT_W-1:0]         i_format_code,
    input  logic [afq_pkg::RATE_W-1:0]        i_frame_hz,
    input  logic [afq_pkg::CHAN_W-1:0]        i_channel_count,
    input  logic [afq_pkg::SBITS_W-1:0]       i_sample_bits,
    input  logic [afq_pkg::STAMP_W-1:0]       i_timestamp,
    input  logic                              i_session_active,
    input  logic                              i_fmt_chosen,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [afq_pkg::STAT_W-1:0]        o_status,
    output logic                              o_popped_valid,
    output logic [afq_pkg::LEN_W-1:0]         o_popped_bytes,
    output logic [afq_pkg::STAMP_W-1:0]       o_popped_timestamp,
    output logic                              o_forwarded,
    output logic [afq_pkg::DROP_W-1:0]        o_dropped_now,
    output logic [afq_pkg::TOTAL_W-1:0]       o_queued_total,
    output logic [afq_pkg::ECNT_W-1:0]        o_entry_count,
    output logic [afq_pkg::CTR_W-1:0]         o_dropped_total,
    output logic [afq_pkg::CTR_W-1:0]         o_submitted_total,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [afq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [afq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import afq_pkg::*;

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Configuration registers.
    logic [TOTAL_W-1:0] r_max_queue;
    logic [LEN_W-1:0]   r_max_frame;
    logic [FMT_W-1:0]   r_req_format;
    logic [RATE_W-1:0]  r_req_rate;
    logic [CHAN_W-1:0]  r_req_chans;
    logic [SBITS_W-1:0] r_req_sbits;

    // Controller and queue bookkeeping.
    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_head, n_head;
    logic [ADDR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]   r_occ, n_occ;
    logic [SUM_W-1:0]   r_bytes, n_bytes;
    logic [CTR_W-1:0]   r_drop_ctr, n_drop_ctr;
    logic [CTR_W-1:0]   r_sub_ctr, n_sub_ctr;
    logic               r_wrote, n_wrote;
    logic               r_out_valid, n_out_valid;

    // Captured request.
    logic [MODE_W-1:0]  r_in_mode, n_in_mode;
    logic [LEN_W-1:0]   r_in_bytes, n_in_bytes;
    logic               r_in_data, n_in_data;
    logic [FMT_W-1:0]   r_in_fmt, n_in_fmt;
    logic [RATE_W-1:0]  r_in_rate, n_in_rate;
    logic [CHAN_W-1:0]  r_in_chans, n_in_chans;
    logic [SBITS_W-1:0] r_in_sbits, n_in_sbits;
    logic [STAMP_W-1:0] r_in_stamp, n_in_stamp;
    logic               r_in_session, n_in_session;
    logic               r_in_selected, n_in_selected;

    // Result being built.
    logic [STAT_W-1:0]  r_status, n_status;
    logic               r_pop_valid, n_pop_valid;
    logic [LEN_W-1:0]   r_pop_bytes, n_pop_bytes;
    logic [STAMP_W-1:0] r_pop_stamp, n_pop_stamp;
    logic               r_fwd, n_fwd;
    logic [DROP_W-1:0]  r_drop_now, n_drop_now;

    // Output register.
    logic [STAT_W-1:0]  r_o_status, n_o_status;
    logic               r_o_pop_valid, n_o_pop_valid;
    logic [LEN_W-1:0]   r_o_pop_bytes, n_o_pop_bytes;
    logic [STAMP_W-1:0] r_o_pop_stamp, n_o_pop_stamp;
    logic               r_o_fwd, n_o_fwd;
    logic [DROP_W-1:0]  r_o_drop_now, n_o_drop_now;
    logic [TOTAL_W-1:0] r_o_queued, n_o_queued;
    logic [ECNT_W-1:0]  r_o_entries, n_o_entries;
    logic [CTR_W-1:0]   r_o_drop_tot, n_o_drop_tot;
    logic [CTR_W-1:0]   r_o_sub_tot, n_o_sub_tot;

    t_ring_ctl          ring_ctl;
    logic [LEN_W-1:0]   rd_len;
    logic [STAMP_W-1:0] rd_stamp;
    logic               in_xfer;
    logic               out_free;
    logic               frame_bad;
    logic               format_bad;
    logic [CNT_W+ECNT_W-1:0] occ_ext;

    afq_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ring (
        .i_clk      (i_clk),
        .i_ctl      (ring_ctl),
        .i_wr_addr  (r_tail),
        .i_rd_addr  (r_head),
        .i_wr_len   (r_in_bytes),
        .i_wr_stamp (r_in_stamp),
        .o_rd_len   (rd_len),
        .o_rd_stamp (rd_stamp)
    );

    // The controller takes a request only from idle, so the stall is a pure state decode.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // A frame is invalid with no payload, zero length or a length over the frame limit.
    assign frame_bad  = !r_in_data || (r_in_bytes == '0) || (r_in_bytes > r_max_frame);
    assign format_bad = (r_in_fmt != r_req_format) || (r_in_rate != r_req_rate) ||
                        (r_in_chans != r_req_chans) || (r_in_sbits != r_req_sbits);

    // Entry count is reported modulo 32, whatever the ring depth.
    assign occ_ext = {{ECNT_W{1'b0}}, r_occ};

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_occ         = r_occ;
        n_bytes       = r_bytes;
        n_drop_ctr    = r_drop_ctr;
        n_sub_ctr     = r_sub_ctr;
        n_wrote       = r_wrote;
        n_out_valid   = r_out_valid && i_out_stall;
        n_in_mode     = r_in_mode;
        n_in_bytes    = r_in_bytes;
        n_in_data     = r_in_data;
        n_in_fmt      = r_in_fmt;
        n_in_rate     = r_in_rate;
        n_in_chans    = r_in_chans;
        n_in_sbits    = r_in_sbits;
        n_in_stamp    = r_in_stamp;
        n_in_session  = r_in_session;
        n_in_selected = r_in_selected;
        n_status      = r_status;
        n_pop_valid   = r_pop_valid;
        n_pop_bytes   = r_pop_bytes;
        n_pop_stamp   = r_pop_stamp;
        n_fwd         = r_fwd;
        n_drop_now    = r_drop_now;
        n_o_status    = r_o_status;
        n_o_pop_valid = r_o_pop_valid;
        n_o_pop_bytes = r_o_pop_bytes;
        n_o_pop_stamp = r_o_pop_stamp;
        n_o_fwd       = r_o_fwd;
        n_o_drop_now  = r_o_drop_now;
        n_o_queued    = r_o_queued;
        n_o_entries   = r_o_entries;
        n_o_drop_tot  = r_o_drop_tot;
        n_o_sub_tot   = r_o_sub_tot;
        ring_ctl      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_in_mode     = i_mode;
                    n_in_bytes    = i_frame_bytes;
                    n_in_data     = i_data_present;
                    n_in_fmt      = i_format_code;
                    n_in_rate     = i_frame_hz;
                    n_in_chans    = i_channel_count;
                    n_in_sbits    = i_sample_bits;
                    n_in_stamp    = i_timestamp;
                    n_in_session  = i_session_active;
                    n_in_selected = i_fmt_chosen;
                    n_status      = STAT_OK;
                    n_pop_valid   = 1'b0;
                    n_pop_bytes   = '0;
                    n_pop_stamp   = '0;
                    n_fwd         = 1'b0;
                    n_drop_now    = '0;
                    n_wrote       = 1'b0;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_DONE;
                unique case (r_in_mode)
                    MODE_SUBMIT: begin
                        if (frame_bad) begin
                            n_status = STAT_INVALID;
                        end else if (format_bad) begin
                            n_status = STAT_UNSUPPORTED;
                        end else if (!r_in_session || !r_in_selected) begin
                            n_status = STAT_NO_SESSION;
                        end else if (r_occ == CNT_W'(QUEUE_DEPTH)) begin
                            // Full ring: the oldest entry makes room first.
                            ring_ctl.rd_en = 1'b1;
                            n_state        = S_TAKE;
                        end else begin
                            n_state = S_WRITE;
                        end
                    end
                    MODE_POP: begin
                        if (r_occ == '0) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            ring_ctl.rd_en = 1'b1;
                            n_state        = S_TAKE;
                        end
                    end
                    MODE_FLUSH: begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_occ   = '0;
                        n_bytes = '0;
                    end
                    MODE_CLEAR: begin
                        n_drop_ctr = '0;
                        n_sub_ctr  = '0;
                    end
                    default: begin
                        n_status = STAT_OK;
                    end
                endcase
            end
            S_TAKE: begin
                // The head entry read in the previous cycle leaves the queue.
                n_head  = (r_head == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + ADDR_W'(1);
                n_occ   = r_occ - CNT_W'(1);
                n_bytes = (r_bytes >= SUM_W'(rd_len)) ? r_bytes - SUM_W'(rd_len) : '0;
                if (r_in_mode == MODE_POP) begin
                    n_pop_valid = 1'b1;
                    n_pop_bytes = rd_len;
                    n_pop_stamp = rd_stamp;
                    n_fwd       = r_in_selected;
                    n_state     = S_DONE;
                end else begin
                    n_drop_ctr = r_drop_ctr + CTR_W'(1);
                    n_drop_now = (r_drop_now == '1) ? r_drop_now : r_drop_now + DROP_W'(1);
                    n_state    = r_wrote ? S_CHECK : S_WRITE;
                end
            end
            S_WRITE: begin
                ring_ctl.wr_en = 1'b1;
                n_tail    = (r_tail == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + ADDR_W'(1);
                n_occ     = r_occ + CNT_W'(1);
                n_bytes   = r_bytes + SUM_W'(r_in_bytes);
                n_sub_ctr = r_sub_ctr + CTR_W'(1);
                n_wrote   = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                // Drop from the head until the queued bytes fit the budget.
                if ((r_bytes > SUM_W'(r_max_queue)) && (r_occ != '0)) begin
                    ring_ctl.rd_en = 1'b1;
                    n_state        = S_TAKE;
                end else begin
                    if (r_occ == '0) begin
                        n_bytes = '0;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_o_status    = r_status;
                    n_o_pop_valid = r_pop_valid;
                    n_o_pop_bytes = r_pop_bytes;
                    n_o_pop_stamp = r_pop_stamp;
                    n_o_fwd       = r_fwd;
                    n_o_drop_now  = r_drop_now;
                    n_o_queued    = r_bytes[TOTAL_W-1:0];
                    n_o_entries   = occ_ext[ECNT_W-1:0];
                    n_o_drop_tot  = r_drop_ctr;
                    n_o_sub_tot   = r_sub_ctr;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_occ        <= '0;
            r_bytes      <= '0;
            r_drop_ctr   <= '0;
            r_sub_ctr    <= '0;
            r_wrote      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_max_queue  <= RST_MAX_QUEUE_BYTES;
            r_max_frame  <= RST_MAX_FRAME_BYTES;
            r_req_format <= RST_REQ_FORMAT;
            r_req_rate   <= RST_REQ_RATE;
            r_req_chans  <= RST_REQ_CHANNELS;
            r_req_sbits  <= RST_REQ_SAMPLE_BITS;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_bytes     <= n_bytes;
            r_drop_ctr  <= n_drop_ctr;
            r_sub_ctr   <= n_sub_ctr;
            r_wrote     <= n_wrote;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAX_QUEUE_BYTES: r_max_queue  <= i_cfg_data[TOTAL_W-1:0];
                    CFG_MAX_FRAME_BYTES: r_max_frame  <= i_cfg_data[LEN_W-1:0];
                    CFG_REQ_FORMAT:      r_req_format <= i_cfg_data[FMT_W-1:0];
                    CFG_REQ_RATE:        r_req_rate   <= i_cfg_data[RATE_W-1:0];
                    CFG_REQ_CHANNELS:    r_req_chans  <= i_cfg_data[CHAN_W-1:0];
                    CFG_REQ_SAMPLE_BITS: r_req_sbits  <= i_cfg_data[SBITS_W-1:0];
                    default: begin
                        r_max_queue <= r_max_queue;
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_in_mode     <= n_in_mode;
        r_in_bytes    <= n_in_bytes;
        r_in_data     <= n_in_data;
        r_in_fmt      <= n_in_fmt;
        r_in_rate     <= n_in_rate;
        r_in_chans    <= n_in_chans;
        r_in_sbits    <= n_in_sbits;
        r_in_stamp    <= n_in_stamp;
        r_in_session  <= n_in_session;
        r_in_selected <= n_in_selected;
        r_status      <= n_status;
        r_pop_valid   <= n_pop_valid;
        r_pop_bytes   <= n_pop_bytes;
        r_pop_stamp   <= n_pop_stamp;
        r_fwd         <= n_fwd;
        r_drop_now    <= n_drop_now;
        r_o_status    <= n_o_status;
        r_o_pop_valid <= n_o_pop_valid;
        r_o_pop_bytes <= n_o_pop_bytes;
        r_o_pop_stamp <= n_o_pop_stamp;
        r_o_fwd       <= n_o_fwd;
        r_o_drop_now  <= n_o_drop_now;
        r_o_queued    <= n_o_queued;
        r_o_entries   <= n_o_entries;
        r_o_drop_tot  <= n_o_drop_tot;
        r_o_sub_tot   <= n_o_sub_tot;
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_popped_valid     = r_o_pop_valid;
    assign o_popped_bytes     = r_o_pop_bytes;
    assign o_popped_timestamp = r_o_pop_stamp;
    assign o_forwarded        = r_o_fwd;
    assign o_dropped_now      = r_o_drop_now;
    assign o_queued_total     = r_o_queued;
    assign o_entry_count      = r_o_entries;
    assign o_dropped_total    = r_o_drop_tot;
    assign o_submitted_total  = r_o_sub_tot;

`ifndef SYNTHESIS
    // The ring never holds more descriptors than it has slots.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy exceeds ring depth");

    // The controller never reads and writes the ring in the same cycle.
    a_ring_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ring_ctl.wr_en && ring_ctl.rd_en))
        else $error("ring read and write collide");

    // An empty queue carries no bytes once a request has been finished.
    a_empty_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_occ == '0) |-> (r_bytes == '0))
        else $error("empty queue with nonzero byte total");

    // A transfer on the request side always starts the controller.
    a_xfer_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_EVAL))
        else $error("accepted request did not start evaluation");
`endif

endmodule

[rtl/afq_ring.sv]
`timescale 1ns / 1ps
// Descriptor ring storage: length and timestamp memories with registered reads.
module afq_ring #(
    parameter int QUEUE_DEPTH = afq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ADDR_W      = $clog2(QUEUE_DEPTH)
) (
    input  logic                        i_clk,
    input  afq_pkg::t_ring_ctl          i_ctl,
    input  logic [ADDR_W-1:0]           i_wr_addr,
    input  logic [ADDR_W-1:0]           i_rd_addr,
    input  logic [afq_pkg::LEN_W-1:0]   i_wr_len,
    input  logic [afq_pkg::STAMP_W-1:0] i_wr_stamp,
    output logic [afq_pkg::LEN_W-1:0]   o_rd_len,
    output logic [afq_pkg::STAMP_W-1:0] o_rd_stamp
);
    import afq_pkg::*;

    logic [LEN_W-1:0]   length_ring [QUEUE_DEPTH];
    logic [STAMP_W-1:0] stamp_ring  [QUEUE_DEPTH];
    logic [LEN_W-1:0]   r_rd_len;
    logic [STAMP_W-1:0] r_rd_stamp;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            length_ring[i_wr_addr] <= i_wr_len;
            stamp_ring[i_wr_addr]  <= i_wr_stamp;
        end
        if (i_ctl.rd_en) begin
            r_rd_len   <= length_ring[i_rd_addr];
            r_rd_stamp <= stamp_ring[i_rd_addr];
        end
    end

    assign o_rd_len   = r_rd_len;
    assign o_rd_stamp = r_rd_stamp;

endmodule
